/* hw/rtl/srdp_pkg.sv */
// ----------------------------------------------------------------------------
// srdp_pkg: shared types and constants for the sparse row dot product
// Holds the field widths, command and operation codes and the queue entry type.
// ----------------------------------------------------------------------------
`default_nettype none

package srdp_pkg;

    localparam int unsigned CMD_W   = 2;
    localparam int unsigned IDX_W   = 10;
    localparam int unsigned VAL_W   = 32;
    localparam int unsigned SUM_W   = 64;
    localparam int unsigned ROW_W   = 16;
    localparam int unsigned NCOL_W  = 11;
    localparam int unsigned QUEUE_DEPTH = 4;

    localparam logic [NCOL_W-1:0] NUM_COLS_RESET = 11'd1024;

    // Input command codes
    localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
    localparam logic [CMD_W-1:0] CMD_MAC  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_EOR  = 2'd2;

    // Operation kinds after classification
    typedef logic [1:0] t_kind;
    localparam t_kind KIND_LOAD = 2'd0;  // write vector element
    localparam t_kind KIND_MAC  = 2'd1;  // in-range nonzero
    localparam t_kind KIND_SKIP = 2'd2;  // out-of-range nonzero
    localparam t_kind KIND_EOR  = 2'd3;  // end of row

    typedef struct packed {
        t_kind                   kind;
        logic [IDX_W-1:0]        index;
        logic signed [VAL_W-1:0] value;
    } t_op;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

endpackage

`default_nettype wire

/* hw/rtl/srdp_front.sv */
// ----------------------------------------------------------------------------
// srdp_front: input classifier
// Holds the column count, checks each item and turns it into a queue operation or drops it.
// ----------------------------------------------------------------------------
`default_nettype none

module srdp_front #(
    parameter int unsigned MAX_COLS = 1024
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_wr_en,
    input  wire logic [srdp_pkg::NCOL_W-1:0]    i_cfg_wr_data,
    input  wire logic                           i_valid,
    input  wire logic [srdp_pkg::CMD_W-1:0]     i_cmd,
    input  wire logic [srdp_pkg::IDX_W-1:0]     i_index,
    input  wire logic [srdp_pkg::VAL_W-1:0]     i_value,
    input  wire logic                           i_queue_full,
    output logic                                o_ready,
    output logic                                o_push,
    output srdp_pkg::t_op                       o_op
);

    logic [srdp_pkg::NCOL_W-1:0] r_num_cols;
    logic                        w_in_max;
    logic                        w_in_cols;
    logic                        w_accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_cols <= srdp_pkg::NUM_COLS_RESET;
        end else if (i_cfg_wr_en) begin
            r_num_cols <= i_cfg_wr_data;
        end
    end

    assign w_in_max  = (32'(i_index) < 32'(MAX_COLS));
    assign w_in_cols = ({1'b0, i_index} < r_num_cols);
    assign o_ready   = !i_queue_full;
    assign w_accept  = i_valid && o_ready;

    // Drop unused commands and loads beyond the store
    always_comb begin
        o_push        = 1'b0;
        o_op.index    = i_index;
        o_op.value    = i_value;
        o_op.kind     = srdp_pkg::KIND_EOR;
        case (i_cmd)
            srdp_pkg::CMD_LOAD: begin
                o_op.kind = srdp_pkg::KIND_LOAD;
                o_push    = w_accept && w_in_max;
            end
            srdp_pkg::CMD_MAC: begin
                o_op.kind = (w_in_max && w_in_cols) ? srdp_pkg::KIND_MAC
                                                    : srdp_pkg::KIND_SKIP;
                o_push    = w_accept;
            end
            srdp_pkg::CMD_EOR: begin
                o_op.kind = srdp_pkg::KIND_EOR;
                o_push    = w_accept;
            end
            default: begin
                o_push = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

/* hw/rtl/srdp_queue.sv */
// ----------------------------------------------------------------------------
// srdp_queue: operation queue
// Short register queue that decouples the classifier from the compute back end.
// ----------------------------------------------------------------------------
`default_nettype none

module srdp_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire srdp_pkg::t_op i_op,
    input  wire logic          i_pop,
    output logic               o_full,
    output logic               o_not_empty,
    output srdp_pkg::t_op      o_op
);

    localparam int unsigned DEPTH = srdp_pkg::QUEUE_DEPTH;
    localparam int unsigned PW    = $clog2(DEPTH);
    localparam int unsigned CW    = $clog2(DEPTH + 1);

    srdp_pkg::t_op r_slot [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          w_pop;

    assign o_full      = (r_count == CW'(DEPTH));
    assign o_not_empty = (r_count != '0);
    assign o_op        = r_slot[r_rd_ptr];
    assign w_pop       = i_pop && o_not_empty;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PW'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
            if (i_push && !w_pop) begin
                r_count <= r_count + CW'(1);
            end else if (!i_push && w_pop) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/srdp_back.sv */
// ----------------------------------------------------------------------------
// srdp_back: vector store, multiplier and accumulator
// Runs queued operations through read, multiply and accumulate stages.
// ----------------------------------------------------------------------------
`default_nettype none

module srdp_back #(
    parameter int unsigned MAX_COLS = 1024
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_op_valid,
    input  wire srdp_pkg::t_op                         i_op,
    output logic                                       o_pop,
    output logic                                       o_valid,
    input  wire logic                                  i_ready,
    output logic signed [srdp_pkg::SUM_W-1:0]          o_row_sum,
    output logic [srdp_pkg::ROW_W-1:0]                 o_row_number,
    output logic                                       o_bad_index
);

    localparam int unsigned AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

    logic [srdp_pkg::VAL_W-1:0] r_mem [MAX_COLS];

    // Read stage
    logic                              r1_valid;
    srdp_pkg::t_kind                   r1_kind;
    logic signed [srdp_pkg::VAL_W-1:0] r1_value;
    logic signed [srdp_pkg::VAL_W-1:0] r1_rd_data;
    // Multiply stage
    logic                              r2_valid;
    srdp_pkg::t_kind                   r2_kind;
    logic signed [srdp_pkg::SUM_W-1:0] r2_prod;
    // Accumulate state
    logic signed [srdp_pkg::SUM_W-1:0] r_acc;
    logic                              r_err;
    logic [srdp_pkg::ROW_W-1:0]        r_row;
    logic signed [srdp_pkg::SUM_W-1:0] n_acc;
    logic signed [srdp_pkg::SUM_W-1:0] w_sum;
    logic                              w_ovf;
    logic                              w_eor;
    logic                              w_en;
    logic [AW-1:0]                     w_addr;

    assign w_addr = AW'(i_op.index);
    assign w_eor  = r2_valid && (r2_kind == srdp_pkg::KIND_EOR);
    // Hold every stage while a finished row waits on a full output
    assign w_en   = !(w_eor && o_valid && !i_ready);
    assign o_pop  = w_en;

    always_ff @(posedge i_clk) begin
        if (w_en && i_op_valid) begin
            if (i_op.kind == srdp_pkg::KIND_LOAD) begin
                r_mem[w_addr] <= i_op.value;
            end
            r1_rd_data <= r_mem[w_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_kind  <= i_op.kind;
            r1_value <= i_op.value;
            r2_kind  <= r1_kind;
            r2_prod  <= r1_value * r1_rd_data;
        end
    end

    assign w_sum = r_acc + r2_prod;
    assign w_ovf = (r_acc[srdp_pkg::SUM_W-1] == r2_prod[srdp_pkg::SUM_W-1])
                && (w_sum[srdp_pkg::SUM_W-1] != r_acc[srdp_pkg::SUM_W-1]);

    always_comb begin
        if (w_ovf) begin
            n_acc = r_acc[srdp_pkg::SUM_W-1] ? srdp_pkg::SUM_MIN : srdp_pkg::SUM_MAX;
        end else begin
            n_acc = w_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r_acc    <= '0;
            r_err    <= 1'b0;
            r_row    <= '0;
            o_valid  <= 1'b0;
        end else begin
            if (w_en) begin
                r1_valid <= i_op_valid && (i_op.kind != srdp_pkg::KIND_LOAD);
                r2_valid <= r1_valid;
                if (r2_valid) begin
                    case (r2_kind)
                        srdp_pkg::KIND_MAC: begin
                            r_acc <= n_acc;
                        end
                        srdp_pkg::KIND_SKIP: begin
                            r_err <= 1'b1;
                        end
                        srdp_pkg::KIND_EOR: begin
                            r_acc <= '0;
                            r_err <= 1'b0;
                            r_row <= r_row + srdp_pkg::ROW_W'(1);
                        end
                        default: begin
                        end
                    endcase
                end
            end
            if (w_en && w_eor) begin
                o_valid <= 1'b1;
            end else if (i_ready) begin
                o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && w_eor) begin
            o_row_sum    <= r_acc;
            o_row_number <= r_row;
            o_bad_index  <= r_err;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/sparse_row_dot_product.sv */
// ----------------------------------------------------------------------------
// sparse_row_dot_product: streaming CSR sparse matrix-vector multiply
// Loads the dense vector, multiplies each nonzero by its vector element and
// emits one saturated Q32.32 row sum per end-of-row transaction.
// ----------------------------------------------------------------------------
//
//  channel   direction  tdata (low bit up)                 tuser
//  s_axis    in         index[9:0], value[41:10], pad      cmd[1:0]
//  m_axis    out        row_sum[63:0], row_number[79:64]   bad_index[0]
//  cfg       in         num_cols[10:0] on i_cfg_wr_en      -
//
//  One transaction per cycle sustained; the single-port vector store and one
//  32x32 multiplier each serve one item per cycle. An end of row reaches
//  m_axis through the queue and the read, multiply and accumulate stages.
//  Reset is synchronous and active low; the vector store is not cleared.
//  A full four-entry queue drops s_axis tready; the back end stalls only when
//  a finished row meets an output transaction that has not been taken.
// ----------------------------------------------------------------------------
`default_nettype none

module sparse_row_dot_product #(
    parameter int unsigned MAX_COLS = 1024
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // Configuration write
    input  wire logic         i_cfg_wr_en,
    input  wire logic [10:0]  i_cfg_wr_data,     // num_cols
    // Input stream
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  wire logic [47:0]  i_s_axis_tdata,    // index[9:0], value[41:10], zero pad
    input  wire logic [1:0]   i_s_axis_tuser,    // cmd[1:0]
    // Result stream
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    output logic [79:0]       o_m_axis_tdata,    // row_sum[63:0], row_number[79:64]
    output logic [0:0]        o_m_axis_tuser     // bad_index
);

    logic          w_push;
    logic          w_pop;
    logic          w_full;
    logic          w_not_empty;
    srdp_pkg::t_op w_front_op;
    srdp_pkg::t_op w_head_op;

    logic signed [srdp_pkg::SUM_W-1:0] w_row_sum;
    logic [srdp_pkg::ROW_W-1:0]        w_row_number;
    logic                              w_bad_index;

    // Classify: range-check against num_cols and the store size
    srdp_front #(
        .MAX_COLS (MAX_COLS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (i_s_axis_tvalid),
        .i_cmd         (i_s_axis_tuser),
        .i_index       (i_s_axis_tdata[9:0]),
        .i_value       (i_s_axis_tdata[41:10]),
        .i_queue_full  (w_full),
        .o_ready       (o_s_axis_tready),
        .o_push        (w_push),
        .o_op          (w_front_op)
    );

    // Buffer classified operations
    srdp_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_op        (w_front_op),
        .i_pop       (w_pop),
        .o_full      (w_full),
        .o_not_empty (w_not_empty),
        .o_op        (w_head_op)
    );

    // Store, multiply, accumulate and emit
    srdp_back #(
        .MAX_COLS (MAX_COLS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op_valid   (w_not_empty),
        .i_op         (w_head_op),
        .o_pop        (w_pop),
        .o_valid      (o_m_axis_tvalid),
        .i_ready      (i_m_axis_tready),
        .o_row_sum    (w_row_sum),
        .o_row_number (w_row_number),
        .o_bad_index  (w_bad_index)
    );

    assign o_m_axis_tdata = {w_row_number, w_row_sum};
    assign o_m_axis_tuser = w_bad_index;

endmodule

`default_nettype wire

/* bench/tb_sparse_row_dot_product.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sparse_row_dot_product: self-checking bench for the sparse row dot product
// A short table of directed transactions covers saturation, skipped columns and
// the column count extremes. Random CSR rows follow under several idle and
// stall mixes. Rows are checked against a local Q32.32 predictor or typed result.
// ----------------------------------------------------------------------------

module tb_sparse_row_dot_product;

    localparam int unsigned CLK_PERIOD      = 10;
    localparam int unsigned MAX_COLS        = 1024;
    localparam int unsigned PIPE_SETTLE     = 10;    // settle time after every owed row is out
    localparam int unsigned HOLD_CYCLES     = 400;   // long result-side hold-off
    localparam int unsigned QUIET_LIMIT     = 2000;  // cycles without any transaction
    localparam int unsigned ITEMS_PER_PHASE = 180;
    localparam int unsigned N_PHASES        = 6;
    localparam int unsigned PRESSURE_PHASE  = 4;
    localparam int unsigned N_DIRECTED      = 24;

    // cmd 3 has no code in the package; the block must ignore it
    localparam logic [srdp_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    // Saturation limits as typed into the directed table
    localparam logic [srdp_pkg::SUM_W-1:0] SAT_HI = srdp_pkg::SUM_MAX;
    localparam logic [srdp_pkg::SUM_W-1:0] SAT_LO = srdp_pkg::SUM_MIN;

    typedef struct packed {
        logic [srdp_pkg::SUM_W-1:0] sum;
        logic [srdp_pkg::ROW_W-1:0] row;
        logic                       bad;
    } t_row_result;

    // One directed transaction; sum/row/bad are used only where known is set
    typedef struct packed {
        logic [srdp_pkg::NCOL_W-1:0] cols;
        logic [srdp_pkg::CMD_W-1:0]  cmd;
        logic [srdp_pkg::IDX_W-1:0]  idx;
        logic [srdp_pkg::VAL_W-1:0]  val;
        logic                        known;
        logic [srdp_pkg::SUM_W-1:0]  sum;
        logic [srdp_pkg::ROW_W-1:0]  row;
        logic                        bad;
    } t_directed_row;

    // ------------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------------
    logic               i_clk           = 1'b0;
    logic               i_rst_n         = 1'b0;
    logic               i_cfg_wr_en     = 1'b0;
    logic [10:0]        i_cfg_wr_data   = '0;
    logic               i_s_axis_tvalid = 1'b0;
    logic               o_s_axis_tready;
    logic [47:0]        i_s_axis_tdata  = '0;  // index[9:0], value[41:10], zero pad
    logic [1:0]         i_s_axis_tuser  = '0;  // cmd[1:0]
    logic               o_m_axis_tvalid;
    logic               i_m_axis_tready = 1'b0;
    logic [79:0]        o_m_axis_tdata;        // row_sum[63:0], row_number[79:64]
    logic [0:0]         o_m_axis_tuser;        // bad_index

    sparse_row_dot_product #(
        .MAX_COLS (MAX_COLS)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Predictor state: vector store, row accumulator, row counter, error flag
    // ------------------------------------------------------------------------
    logic [srdp_pkg::VAL_W-1:0]  vec_elem    [MAX_COLS];
    bit                          elem_loaded [MAX_COLS];
    logic [srdp_pkg::SUM_W-1:0]  row_acc     = '0;
    logic [srdp_pkg::ROW_W-1:0]  row_count   = '0;
    logic                        row_flag    = 1'b0;
    logic [srdp_pkg::NCOL_W-1:0] active_cols = srdp_pkg::NUM_COLS_RESET;

    t_row_result       pending_rows [$];   // row results still owed by the block

    int unsigned       errors         = 0;
    int unsigned       items_sent     = 0;
    int unsigned       send_idle_pct  = 0;
    int unsigned       recv_stall_pct = 0;
    int unsigned       hold_asks      = 0;
    int unsigned       holds_served   = 0;
    int unsigned       hold_left      = 0;
    int unsigned       quiet_cycles   = 0;

    // Add with clamping to the signed 64-bit range
    function automatic logic [srdp_pkg::SUM_W-1:0] sat_sum(
            input logic [srdp_pkg::SUM_W-1:0] a,
            input logic [srdp_pkg::SUM_W-1:0] b);
        logic [srdp_pkg::SUM_W:0] s;
        s = {a[srdp_pkg::SUM_W-1], a} + {b[srdp_pkg::SUM_W-1], b};
        if (s[srdp_pkg::SUM_W] != s[srdp_pkg::SUM_W-1])
            return s[srdp_pkg::SUM_W] ? srdp_pkg::SUM_MIN : srdp_pkg::SUM_MAX;
        return s[srdp_pkg::SUM_W-1:0];
    endfunction

    // Advance the predictor by one accepted transaction
    task automatic accumulate_item(input logic [srdp_pkg::CMD_W-1:0] cmd,
                                   input logic [srdp_pkg::IDX_W-1:0] idx,
                                   input logic [srdp_pkg::VAL_W-1:0] val);
        t_row_result                done;
        logic [srdp_pkg::SUM_W-1:0] prod;
        case (cmd)
            srdp_pkg::CMD_LOAD: begin
                // written even when the index is past the column count
                vec_elem[idx]    = val;
                elem_loaded[idx] = 1'b1;
            end
            srdp_pkg::CMD_MAC: begin
                if (idx >= active_cols || idx >= MAX_COLS) begin
                    row_flag = 1'b1;
                end else begin
                    // Q16.16 times Q16.16 is exactly Q32.32
                    prod = $signed({{32{val[srdp_pkg::VAL_W-1]}}, val})
                         * $signed({{32{vec_elem[idx][srdp_pkg::VAL_W-1]}},
                                    vec_elem[idx]});
                    row_acc = sat_sum(row_acc, prod);
                end
            end
            srdp_pkg::CMD_EOR: begin
                done.sum = row_acc;
                done.row = row_count;
                done.bad = row_flag;
                pending_rows = {pending_rows, done};
                row_acc   = '0;
                row_flag  = 1'b0;
                row_count = row_count + srdp_pkg::ROW_W'(1);
            end
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Input side: offer one transaction, hold it until taken
    // ------------------------------------------------------------------------
    task automatic send_item(input logic [srdp_pkg::CMD_W-1:0] cmd,
                             input logic [srdp_pkg::IDX_W-1:0] idx,
                             input logic [srdp_pkg::VAL_W-1:0] val);
        if (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99, 0) < send_idle_pct);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {6'b0, val, idx};
        i_s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (!o_s_axis_tready);
        accumulate_item(cmd, idx, val);
        if (cmd != CMD_UNUSED)
            items_sent++;
    endtask

    // Drop valid, wait until every owed row has come out, then let the pipe settle
    task automatic wait_rows_drained();
        i_s_axis_tvalid <= 1'b0;
        while (pending_rows.size() != 0)
            @(posedge i_clk);
        repeat (PIPE_SETTLE) @(posedge i_clk);
    endtask

    task automatic write_num_cols(input logic [srdp_pkg::NCOL_W-1:0] cols);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= cols;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        active_cols    = cols;
    endtask

    // Mostly random Q16.16, with the two extremes often enough to saturate
    function automatic logic [srdp_pkg::VAL_W-1:0] rand_q16(input bit hot);
        if (hot || $urandom_range(7, 0) == 0)
            return $urandom_range(1, 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        return $urandom;
    endfunction

    // One CSR row: nonzeros (loading any unset element first), then end of row.
    // Sprinkle unused commands, stray loads and out-of-range columns as noise.
    task automatic send_random_row();
        int unsigned                nnz;
        int unsigned                usable;
        bit                         hot;
        logic [srdp_pkg::IDX_W-1:0] col;
        nnz    = $urandom_range(8, 0);
        hot    = ($urandom_range(11, 0) == 0);
        usable = (active_cols < MAX_COLS) ? active_cols : MAX_COLS;
        for (int k = 0; k < nnz; k++) begin
            if ($urandom_range(19, 0) == 0)
                send_item(CMD_UNUSED, srdp_pkg::IDX_W'($urandom), $urandom);
            if (usable > 0 && $urandom_range(7, 0) != 0)
                col = srdp_pkg::IDX_W'($urandom_range(usable - 1, 0));
            else
                col = srdp_pkg::IDX_W'($urandom_range(MAX_COLS - 1, 0));
            // never let an in-range nonzero read an element that was never loaded
            if ((col < usable && !elem_loaded[col]) || $urandom_range(5, 0) == 0)
                send_item(srdp_pkg::CMD_LOAD, col, rand_q16(hot));
            send_item(srdp_pkg::CMD_MAC, col, rand_q16(hot));
        end
        send_item(srdp_pkg::CMD_EOR, srdp_pkg::IDX_W'($urandom), $urandom);
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stalls, plus a long hold-off on request
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_asks != holds_served) begin
            holds_served    <= hold_asks;
            hold_left       <= HOLD_CYCLES;
            i_m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left       <= hold_left - 1;
            i_m_axis_tready <= 1'b0;
        end else if (recv_stall_pct != 0 && $urandom_range(99, 0) < recv_stall_pct) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    // Check each result transaction against the oldest owed row
    always @(posedge i_clk) begin : row_check
        t_row_result due;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_rows.size() == 0) begin
                errors++;
                $display("%0t: unexpected row result: sum %h row %0d bad %b", $time,
                         o_m_axis_tdata[63:0], o_m_axis_tdata[79:64], o_m_axis_tuser[0]);
            end else begin
                due = pending_rows.pop_front();
                if (o_m_axis_tdata[63:0] !== due.sum || o_m_axis_tdata[79:64] !== due.row ||
                    o_m_axis_tuser[0] !== due.bad) begin
                    errors++;
                    $display("%0t: row mismatch: expected sum %h row %0d bad %b,",
                             $time, due.sum, due.row, due.bad,
                             " got sum %h row %0d bad %b",
                             o_m_axis_tdata[63:0], o_m_axis_tdata[79:64], o_m_axis_tuser[0]);
                end
            end
        end
    end

    // Watchdog: end the run if no transaction moves on either side for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_sparse_row_dot_product failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Directed table. A change in cols drains the block and rewrites num_cols.
    // Rows with known set carry a result read straight off the arithmetic.
    // ------------------------------------------------------------------------
    t_directed_row directed_rows [N_DIRECTED] = '{
        // empty row straight after reset
        '{11'd1024, srdp_pkg::CMD_EOR,  10'd0,    32'h0000_0000, 1'b1, 64'd0,  16'd0, 1'b0},
        '{11'd1024, srdp_pkg::CMD_LOAD, 10'd0,    32'h8000_0000, 1'b0, 64'd0,  16'd0, 1'b0},
        '{11'd1024, srdp_pkg::CMD_LOAD, 10'd1023, 32'h7FFF_FFFF, 1'b0, 64'd0,  16'd0, 1'b0},
        // two products of 2^62 overflow upward
        '{11'd1024, srdp_pkg::CMD_MAC,  10'd0,    32'h8000_0000, 1'b0, 64'd0,  16'd0, 1'b0},
        '{11'd1024, srdp_pkg::CMD_MAC,  10'd0,    32'h8000_0000, 1'b0, 64'd0,  16'd0, 1'b0},
        '{11'd1024, srdp_pkg::CMD_EOR,  10'd1023, 32'hFFFF_FFFF, 1'b1, SAT_HI, 16'd1, 1'b0},
        // three large negative products overflow downward
        '{11'd1024, srdp_pkg::CMD_MAC,  10'd1023, 32'h8000_0000, 1'b0, 64'd0,  16'd0, 1'b0},
        '{11'd1024, srdp_pkg::CMD_MAC,  10'd1023, 32'h8000_0000, 1'b0, 64'd0,  16'd0, 1'b0},
        '{11'd1024, srdp_pkg::CMD_MAC,  10'd1023, 32'h8000_0000, 1'b0, 64'd0,  16'd0, 1'b0},
        '{11'd1024, srdp_pkg::CMD_EOR,  10'd0,    32'h0000_0000, 1'b1, SAT_LO, 16'd2, 1'b0},
        // unused command must leave no trace
        '{11'd1024, CMD_UNUSED,         10'd1023, 32'hFFFF_FFFF, 1'b0, 64'd0,  16'd0, 1'b0},
        '{11'd1024, srdp_pkg::CMD_LOAD, 10'd5,    32'h0001_0000, 1'b0, 64'd0,  16'd0, 1'b0},
        '{11'd1024, srdp_pkg::CMD_MAC,  10'd5,    32'h0002_0000, 1'b0, 64'd0,  16'd0, 1'b0},
        '{11'd1024, srdp_pkg::CMD_EOR,  10'd0,    32'h0000_0000, 1'b0, 64'd0,  16'd0, 1'b0},
        // zero column count skips every nonzero
        '{11'd0,    srdp_pkg::CMD_MAC,  10'd0,    32'h0001_0000, 1'b0, 64'd0,  16'd0, 1'b0},
        '{11'd0,    srdp_pkg::CMD_EOR,  10'd0,    32'h0000_0000, 1'b1, 64'd0,  16'd4, 1'b1},
        // one column: load past the count still lands, nonzero there is skipped
        '{11'd1,    srdp_pkg::CMD_LOAD, 10'd5,    32'h0003_0000, 1'b0, 64'd0,  16'd0, 1'b0},
        '{11'd1,    srdp_pkg::CMD_MAC,  10'd5,    32'h0001_0000, 1'b0, 64'd0,  16'd0, 1'b0},
        '{11'd1,    srdp_pkg::CMD_MAC,  10'd0,    32'h0001_0000, 1'b0, 64'd0,  16'd0, 1'b0},
        '{11'd1,    srdp_pkg::CMD_EOR,  10'd0,    32'h0000_0000, 1'b0, 64'd0,  16'd0, 1'b0},
        // count above the store size is capped by the store
        '{11'd2047, srdp_pkg::CMD_MAC,  10'd1023, 32'h7FFF_FFFF, 1'b0, 64'd0,  16'd0, 1'b0},
        '{11'd2047, srdp_pkg::CMD_MAC,  10'd5,    32'hFFFF_0000, 1'b0, 64'd0,  16'd0, 1'b0},
        '{11'd2047, srdp_pkg::CMD_EOR,  10'd0,    32'h0000_0000, 1'b0, 64'd0,  16'd0, 1'b0},
        '{11'd1024, srdp_pkg::CMD_EOR,  10'd0,    32'h0000_0000, 1'b1, 64'd0,  16'd7, 1'b0}
    };

    // Random phases: column count, sender idle and receiver stall percentages
    int unsigned phase_cols       [N_PHASES] = '{1024, 2047, 1, 300, 1024, 64};
    int unsigned phase_send_idle  [N_PHASES] = '{0,    64,   0, 15,  0,    15};
    int unsigned phase_recv_stall [N_PHASES] = '{0,    0,    64, 15, 0,    15};

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int unsigned phase_end;
        bit          paused;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[n]) begin
            if (directed_rows[n].cols != active_cols) begin
                wait_rows_drained();
                write_num_cols(directed_rows[n].cols);
            end
            send_item(directed_rows[n].cmd, directed_rows[n].idx, directed_rows[n].val);
            // the typed-in result stands in for the prediction
            if (directed_rows[n].known)
                pending_rows[pending_rows.size() - 1] =
                    {directed_rows[n].sum, directed_rows[n].row, directed_rows[n].bad};
        end

        paused = 1'b0;
        for (int ph = 0; ph < N_PHASES; ph++) begin
            wait_rows_drained();
            write_num_cols(srdp_pkg::NCOL_W'(phase_cols[ph]));
            send_idle_pct  = phase_send_idle[ph];
            recv_stall_pct = phase_recv_stall[ph];
            // hold off results while input keeps coming, so the queue fills
            if (ph == PRESSURE_PHASE)
                hold_asks++;
            phase_end = items_sent + ITEMS_PER_PHASE;
            while (items_sent < phase_end) begin
                // halfway through, pause input until every owed row is out
                if (ph == PRESSURE_PHASE && !paused &&
                    items_sent + ITEMS_PER_PHASE / 2 >= phase_end) begin
                    wait_rows_drained();
                    paused = 1'b1;
                end
                send_random_row();
            end
        end

        wait_rows_drained();
        if (errors == 0)
            $display("tb_sparse_row_dot_product passed");
        else
            $display("tb_sparse_row_dot_product failed");
        $finish;
    end

endmodule
